@@ src/bitmap_first_free_allocator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Bitmap first-free allocator: assertion macros
// Shorthand for the clocked, reset-qualified checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bffa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap first-free allocator package
// Widths, request codes, sequencer states and the scan result type.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int WORD_BITS   = 32;
    localparam int WORD_LSB    = 5;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int POS_W       = IDX_W - WORD_LSB;
    localparam int INDEX_REACH = 1 << IDX_W;

    localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(INDEX_REACH);

    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_TOGGLE = 2'd1;
    localparam logic [1:0] KIND_TEST   = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_ACCESS = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    typedef struct packed {
        logic                hit;
        logic                last;
        logic [WORD_LSB-1:0] bit_pos;
    } t_scan_res;

endpackage

@@ src/bffa_word_scan.sv @@
// ----------------------------------------------------------------------------
// Bitmap first-free allocator: word scanner
// Finds the lowest clear bit of one map word that lies inside the scan range
// and flags whether this word is the last one below the limit.
// ----------------------------------------------------------------------------
module bffa_word_scan (
    input  logic [bffa_pkg::WORD_BITS-1:0] i_word,
    input  logic [bffa_pkg::POS_W-1:0]     i_pos,
    input  logic [bffa_pkg::CNT_W-1:0]     i_limit,
    output bffa_pkg::t_scan_res            o_res
);
    import bffa_pkg::*;

    logic [CNT_W-1:0]     base;
    logic [CNT_W-1:0]     rem;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;

    always_comb begin
        base = {1'b0, i_pos, {WORD_LSB{1'b0}}};
        rem  = i_limit - base;
        if (i_limit <= base) begin
            mask = '0;
        end else if (rem >= CNT_W'(WORD_BITS)) begin
            mask = '1;
        end else begin
            mask = (WORD_BITS'(1) << rem[WORD_LSB-1:0]) - WORD_BITS'(1);
        end
        // Index zero is reserved and never handed out.
        if (i_pos == '0) begin
            mask[0] = 1'b0;
        end
        free_bits = ~i_word & mask;

        o_res.hit     = |free_bits;
        o_res.last    = (base + CNT_W'(WORD_BITS)) >= i_limit;
        o_res.bit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                o_res.bit_pos = WORD_LSB'(j);
            end
        end
    end

endmodule

@@ src/bitmap_first_free_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Bitmap first-free allocator
// Allocation bitmap held in a 32-bit-word memory with a set-bit count.
// Serves find-first-free, toggle and test requests, one word at a time.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Direction
//   cfg       i_cfg_valid/o_cfg_ready/data     in  (bits_in_use)
//   in        i_in_valid/o_in_ready/kind,idx   in  (one request word)
//   out       o_out_valid/i_out_ready/fields   out (one result word)
//
// Toggle and test pass through a memory read, modify and write back (toggle only), and result.
// Find reads the 32-bit words in turn, one memory read per cycle, until a free bit or
// the limit is reached (at most 32 words).
// After reset a clearing pass writes zero to each of the (MAP_BITS+31)/32
// words, one per cycle, and no request is taken until it ends.
// A stalled output holds its word; the next request is still taken.
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_top_assert.svh"

module bitmap_first_free_allocator_top #(
    parameter int MAP_BITS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bffa_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic [bffa_pkg::IDX_W-1:0] i_bit_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [bffa_pkg::IDX_W-1:0] o_result_index,
    output logic                       o_bit_value,
    output logic [bffa_pkg::CNT_W-1:0] o_free_count
);
    import bffa_pkg::*;

    localparam int NWORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LIM_CAP_I = (MAP_BITS < INDEX_REACH) ? MAP_BITS : INDEX_REACH;
    localparam logic [CNT_W-1:0] LIM_CAP   = CNT_W'(LIM_CAP_I);
    localparam logic [AW-1:0]    LAST_WORD = AW'(NWORDS - 1);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]     r_bits_in_use;
    logic [CNT_W-1:0]     r_set_count, n_set_count;
    logic [1:0]           r_kind;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_in_range;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [IDX_W-1:0]     r_res_idx, n_res_idx;
    logic                 r_res_val, n_res_val;
    logic                 r_out_valid, n_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic                 r_out_val;
    logic [CNT_W-1:0]     r_out_free;
    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     free_now;
    logic                 in_accept;
    logic                 out_load;
    logic                 cur_bit;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    t_scan_res            scan_res;

    assign limit     = (r_bits_in_use > LIM_CAP) ? LIM_CAP : r_bits_in_use;
    assign free_now  = (r_set_count >= limit) ? '0 : (limit - r_set_count);
    assign in_accept = i_in_valid && o_in_ready;
    assign out_load  = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    assign cur_bit   = r_rd_data[r_idx[WORD_LSB-1:0]];

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_idx;
    assign o_bit_value    = r_out_val;
    assign o_free_count   = r_out_free;

    bffa_word_scan u_scan (
        .i_word  (r_rd_data),
        .i_pos   (r_pos),
        .i_limit (limit),
        .o_res   (scan_res)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_set_count = r_set_count;
        n_pos       = r_pos;
        n_res_idx   = r_res_idx;
        n_res_val   = r_res_val;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_clr_addr;
        wr_data     = '0;

        case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (r_clr_addr == LAST_WORD) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    rd_en = 1'b1;
                    if (i_kind == KIND_FIND) begin
                        n_pos   = '0;
                        n_state = ST_SCAN;
                    end else begin
                        rd_addr = AW'(i_bit_index >> WORD_LSB);
                        n_state = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: begin
                n_res_idx = r_idx;
                n_res_val = 1'b0;
                if (r_in_range) begin
                    if (r_kind == KIND_TOGGLE) begin
                        wr_en     = 1'b1;
                        wr_addr   = AW'(r_idx >> WORD_LSB);
                        wr_data   = r_rd_data ^ (WORD_BITS'(1) << r_idx[WORD_LSB-1:0]);
                        n_res_val = !cur_bit;
                        if (!cur_bit) begin
                            n_set_count = r_set_count + 1'b1;
                        end else if (r_set_count != '0) begin
                            n_set_count = r_set_count - 1'b1;
                        end
                    end else if (r_kind == KIND_TEST) begin
                        n_res_val = cur_bit;
                    end
                end
                n_state = ST_FINISH;
            end
            ST_SCAN: begin
                n_res_val = 1'b0;
                if (scan_res.hit) begin
                    n_res_idx = {r_pos, scan_res.bit_pos};
                    n_state   = ST_FINISH;
                end else if (scan_res.last) begin
                    n_res_idx = '0;
                    n_state   = ST_FINISH;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = AW'(n_pos);
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_bits_in_use <= CFG_RESET;
            r_set_count   <= '0;
            r_out_valid   <= 1'b0;
            r_pos         <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_set_count <= n_set_count;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            if (i_cfg_valid) begin
                r_bits_in_use <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_idx <= n_res_idx;
        r_res_val <= n_res_val;
        if (in_accept) begin
            r_kind     <= i_kind;
            r_idx      <= i_bit_index;
            r_in_range <= {1'b0, i_bit_index} < limit;
        end
        if (out_load) begin
            r_out_idx  <= r_res_idx;
            r_out_val  <= r_res_val;
            r_out_free <= free_now;
        end
    end

    // Map memory: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    `BFFA_ASSERT_NEXT(a_single_item, i_clk, i_rst_n, in_accept, !o_in_ready, "second word taken while busy")
    `BFFA_ASSERT_SAME(a_free_bound, i_clk, i_rst_n, o_out_valid, o_free_count <= limit, "free count above limit")
    `BFFA_ASSERT_SAME(a_write_state, i_clk, i_rst_n, wr_en, (r_state == ST_CLEAR) || (r_state == ST_ACCESS), "map write outside clear or modify")
    `BFFA_ASSERT_SAME(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == ST_FINISH), "result raised without a finished request")

endmodule
